@@ sv/mkt_pkg.sv @@
// ----------------------------------------------------------------------------
// mkt_pkg
// Types, constants and the code table shared by the Morse keyer timing core.
// ----------------------------------------------------------------------------
package mkt_pkg;

  localparam int unsigned CharW       = 8;
  localparam int unsigned DotW        = 16;
  localparam int unsigned DurW        = 19;
  localparam int unsigned MaxElems    = 5;
  localparam int unsigned ElemCntW    = 3;
  localparam int unsigned SegCntW     = 4;
  localparam int unsigned AddrW       = 3;
  localparam int unsigned DataW       = 32;

  localparam logic [DotW-1:0] DotReset      = 16'd250;
  localparam int unsigned     DashDots      = 3;
  localparam int unsigned     LetterGapDots = 3;
  localparam int unsigned     WordGapDots   = 7;

  localparam logic [CharW-1:0] CharSpace = 8'h20;
  localparam logic             RegDotTicks = 1'b0;

  // Pattern is left justified: first element in the top bit, 1 = dash.
  typedef struct packed {
    logic                is_space;
    logic [ElemCntW-1:0] n_elems;
    logic [MaxElems-1:0] pattern;
  } code_t;

  function automatic code_t code_lookup(input logic [CharW-1:0] ch);
    code_t c;
    c.is_space = 1'b0;
    c.n_elems  = 3'd0;
    c.pattern  = 5'b00000;
    case (ch)
      CharSpace: c.is_space = 1'b1;
      "A": begin c.n_elems = 3'd2; c.pattern = 5'b01000; end
      "B": begin c.n_elems = 3'd4; c.pattern = 5'b10000; end
      "C": begin c.n_elems = 3'd4; c.pattern = 5'b10100; end
      "D": begin c.n_elems = 3'd3; c.pattern = 5'b10000; end
      "E": begin c.n_elems = 3'd1; c.pattern = 5'b00000; end
      "F": begin c.n_elems = 3'd4; c.pattern = 5'b00100; end
      "G": begin c.n_elems = 3'd3; c.pattern = 5'b11000; end
      "H": begin c.n_elems = 3'd4; c.pattern = 5'b00000; end
      "I": begin c.n_elems = 3'd2; c.pattern = 5'b00000; end
      "J": begin c.n_elems = 3'd4; c.pattern = 5'b01110; end
      "K": begin c.n_elems = 3'd3; c.pattern = 5'b10100; end
      "L": begin c.n_elems = 3'd4; c.pattern = 5'b01000; end
      "M": begin c.n_elems = 3'd2; c.pattern = 5'b11000; end
      "N": begin c.n_elems = 3'd2; c.pattern = 5'b10000; end
      "O": begin c.n_elems = 3'd3; c.pattern = 5'b11100; end
      "P": begin c.n_elems = 3'd4; c.pattern = 5'b01100; end
      "Q": begin c.n_elems = 3'd4; c.pattern = 5'b11010; end
      "R": begin c.n_elems = 3'd3; c.pattern = 5'b01000; end
      "S": begin c.n_elems = 3'd3; c.pattern = 5'b00000; end
      "T": begin c.n_elems = 3'd1; c.pattern = 5'b10000; end
      "U": begin c.n_elems = 3'd3; c.pattern = 5'b00100; end
      "V": begin c.n_elems = 3'd4; c.pattern = 5'b00010; end
      "W": begin c.n_elems = 3'd3; c.pattern = 5'b01100; end
      "X": begin c.n_elems = 3'd4; c.pattern = 5'b10010; end
      "Y": begin c.n_elems = 3'd4; c.pattern = 5'b10110; end
      "Z": begin c.n_elems = 3'd4; c.pattern = 5'b11000; end
      "0": begin c.n_elems = 3'd5; c.pattern = 5'b11111; end
      "1": begin c.n_elems = 3'd5; c.pattern = 5'b01111; end
      "2": begin c.n_elems = 3'd5; c.pattern = 5'b00111; end
      "3": begin c.n_elems = 3'd5; c.pattern = 5'b00011; end
      "4": begin c.n_elems = 3'd5; c.pattern = 5'b00001; end
      "5": begin c.n_elems = 3'd5; c.pattern = 5'b00000; end
      "6": begin c.n_elems = 3'd5; c.pattern = 5'b10000; end
      "7": begin c.n_elems = 3'd5; c.pattern = 5'b11000; end
      "8": begin c.n_elems = 3'd5; c.pattern = 5'b11100; end
      "9": begin c.n_elems = 3'd5; c.pattern = 5'b11110; end
      default: c.n_elems = 3'd0;
    endcase
    return c;
  endfunction

endpackage

@@ sv/mkt_if.sv @@
// ----------------------------------------------------------------------------
// mkt_char_if / mkt_seg_if
// Valid/ready channels for characters in and key segments out.
// ----------------------------------------------------------------------------
interface mkt_char_if;
  logic                          valid;
  logic                          ready;
  logic [mkt_pkg::CharW-1:0]     character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface mkt_seg_if;
  logic                          valid;
  logic                          ready;
  logic                          key_on;
  logic [mkt_pkg::DurW-1:0]      duration_ticks;
  logic                          last;

  modport source (output valid, output key_on, output duration_ticks, output last,
                  input ready);
  modport sink   (input valid, input key_on, input duration_ticks, input last,
                  output ready);
endinterface

@@ sv/morse_keyer_timing_core.sv @@
// ----------------------------------------------------------------------------
// morse_keyer_timing_core
// Turns ASCII characters into runs of timed key segments (Morse keyer).
// ----------------------------------------------------------------------------
//   channel   dir   handshake     payload
//   char_i    in    valid/ready   character[7:0]
//   seg_o     out   valid/ready   key_on, duration_ticks[18:0], last
//   apb       in    psel/penable  dot_ticks at byte address 0
//
// One segment leaves per cycle from the output register while seg_o is ready; a
// character yields 2*elements+1 segments (1 for space, 1 for unknown codes, up to 11).
// The segment sequencer sets the rate; the next character is taken in the
// cycle its predecessor's last segment moves to the output register.
// Reset clears both valid flags and loads dot_ticks with 250.
// A stalled seg_o holds its segment and the sequencer waits.
// ----------------------------------------------------------------------------
module morse_keyer_timing_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mkt_char_if.sink                      char_i,
  mkt_seg_if.source                     seg_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mkt_pkg::AddrW-1:0]     paddr,
  input  logic [mkt_pkg::DataW-1:0]     pwdata,
  output logic [mkt_pkg::DataW-1:0]     prdata,
  output logic                          pready
);

  logic [mkt_pkg::DotW-1:0]     dot_q;
  logic                         cfg_wr;

  logic                         seq_valid_q, seq_valid_d;
  logic                         space_q;
  logic [mkt_pkg::ElemCntW-1:0] n_elems_q;
  logic [mkt_pkg::MaxElems-1:0] pattern_q, pattern_d;
  logic [mkt_pkg::SegCntW-1:0]  seg_q, seg_d;

  logic                         out_valid_q, out_valid_d;
  logic                         key_on_q, key_on_d;
  logic [mkt_pkg::DurW-1:0]     dur_q, dur_d;
  logic                         last_q, last_d;

  logic                         out_load;
  logic                         char_take;
  mkt_pkg::code_t               code;
  logic [mkt_pkg::DurW-1:0]     dur_dot, dur_dash, dur_letter, dur_word;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == mkt_pkg::RegDotTicks);
  assign prdata = (paddr[2] == mkt_pkg::RegDotTicks) ?
                  {{(mkt_pkg::DataW-mkt_pkg::DotW){1'b0}}, dot_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= mkt_pkg::DotReset;
    end else if (cfg_wr) begin
      dot_q <= pwdata[mkt_pkg::DotW-1:0];
    end
  end

  assign dur_dot    = mkt_pkg::DurW'(dot_q);
  assign dur_dash   = dur_dot * mkt_pkg::DurW'(mkt_pkg::DashDots);
  assign dur_letter = dur_dot * mkt_pkg::DurW'(mkt_pkg::LetterGapDots);
  assign dur_word   = dur_dot * mkt_pkg::DurW'(mkt_pkg::WordGapDots);

  assign out_load = seq_valid_q && (!out_valid_q || seg_o.ready);

  always_comb begin
    last_d   = space_q || (seg_q == {n_elems_q, 1'b0});
    key_on_d = 1'b0;
    dur_d    = dur_dot;
    if (space_q) begin
      dur_d = dur_word;
    end else if (last_d) begin
      dur_d = dur_letter;
    end else if (!seg_q[0]) begin
      key_on_d = 1'b1;
      dur_d    = pattern_q[mkt_pkg::MaxElems-1] ? dur_dash : dur_dot;
    end
  end

  assign char_i.ready = !seq_valid_q || (out_load && last_d);
  assign char_take    = char_i.valid && char_i.ready;
  assign code         = mkt_pkg::code_lookup(char_i.character);

  always_comb begin
    seq_valid_d = seq_valid_q;
    seg_d       = seg_q;
    pattern_d   = pattern_q;
    if (out_load) begin
      seg_d = seg_q + 1'b1;
      if (seg_q[0]) begin
        pattern_d = {pattern_q[mkt_pkg::MaxElems-2:0], 1'b0};
      end
      if (last_d) begin
        seq_valid_d = 1'b0;
      end
    end
    if (char_take) begin
      seq_valid_d = 1'b1;
      seg_d       = '0;
      pattern_d   = code.pattern;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_valid_q <= 1'b0;
    end else begin
      seq_valid_q <= seq_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q     <= seg_d;
    pattern_q <= pattern_d;
    if (char_take) begin
      space_q   <= code.is_space;
      n_elems_q <= code.n_elems;
    end
  end

  assign out_valid_d = out_load || (out_valid_q && !seg_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      key_on_q <= key_on_d;
      dur_q    <= dur_d;
      last_q   <= last_d;
    end
  end

  assign seg_o.valid          = out_valid_q;
  assign seg_o.key_on         = key_on_q;
  assign seg_o.duration_ticks = dur_q;
  assign seg_o.last           = last_q;

endmodule

@@ sv/mkt_checker.sv @@
// ----------------------------------------------------------------------------
// mkt_checker
// Port-level checks on the segment stream of the keyer timing core.
// ----------------------------------------------------------------------------
module mkt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      seg_valid_i,
  input logic                      seg_ready_i,
  input logic                      seg_key_on_i,
  input logic [mkt_pkg::DurW-1:0]  seg_dur_i,
  input logic                      seg_last_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_i && !seg_ready_i |=> seg_valid_i && $stable(seg_key_on_i) &&
    $stable(seg_dur_i) && $stable(seg_last_i))
    else $error("segment changed while stalled");

  a_tone_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_i && seg_key_on_i |-> !seg_last_i)
    else $error("key-down segment marked last");

  a_tone_then_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_valid_i && seg_ready_i && seg_key_on_i |=>
    seg_valid_i && !seg_key_on_i && !seg_last_i)
    else $error("key-down segment not followed by element gap");

endmodule

bind morse_keyer_timing_core mkt_checker u_mkt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .seg_valid_i  (seg_o.valid),
  .seg_ready_i  (seg_o.ready),
  .seg_key_on_i (seg_o.key_on),
  .seg_dur_i    (seg_o.duration_ticks),
  .seg_last_i   (seg_o.last)
);

@@ bench/tb_morse_keyer_timing_core.sv @@
// ----------------------------------------------------------------------------
// tb_morse_keyer_timing_core
// Self-checking bench for the Morse keyer timing core. A directed table covers
// the dot-length extremes, space, unknown codes and the longest codes. Random
// traffic follows, mostly valid letters, digits and spaces. It runs under
// several dot settings, with bursty input and a stalling segment sink. Every
// segment is checked against a predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_morse_keyer_timing_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [mkt_pkg::AddrW-1:0] AddrDotTicks =
    mkt_pkg::AddrW'(4 * mkt_pkg::RegDotTicks);
  localparam logic [mkt_pkg::AddrW-1:0] AddrUnmapped =
    mkt_pkg::AddrW'(4 * (mkt_pkg::RegDotTicks + 1));
  localparam int unsigned      WatchdogLimit = 2000;
  localparam int unsigned      DrainCycles   = 16;
  localparam int unsigned      PhaseItems    = 66;
  localparam int unsigned      NumPhases     = 6;
  localparam int unsigned      NumRows       = 23;
  localparam int unsigned      PrintCap      = 40;

  typedef enum logic {SEND_CHAR, WRITE_REG} row_kind_e;

  typedef struct packed {
    row_kind_e                    kind;
    logic [mkt_pkg::AddrW-1:0]    addr;
    logic [mkt_pkg::DataW-1:0]    value;
    logic                         typed;
    logic [mkt_pkg::DurW-1:0]     dur;
  } stim_row_t;

  typedef struct packed {
    logic                     key_on;
    logic [mkt_pkg::DurW-1:0] dur;
    logic                     last;
  } segment_t;

  localparam stim_row_t DirectedRows [NumRows] = '{
    '{SEND_CHAR, AddrDotTicks, 32'(" "),      1'b1, 19'd1750},
    '{SEND_CHAR, AddrDotTicks, 32'h00,        1'b1, 19'd750},
    '{SEND_CHAR, AddrDotTicks, 32'hFF,        1'b1, 19'd750},
    '{SEND_CHAR, AddrDotTicks, 32'("E"),      1'b0, 19'd0},
    '{SEND_CHAR, AddrDotTicks, 32'("T"),      1'b0, 19'd0},
    '{SEND_CHAR, AddrDotTicks, 32'("0"),      1'b0, 19'd0},
    '{SEND_CHAR, AddrDotTicks, 32'("5"),      1'b0, 19'd0},
    '{SEND_CHAR, AddrDotTicks, 32'("a"),      1'b1, 19'd750},
    '{SEND_CHAR, AddrDotTicks, 32'("Z"),      1'b0, 19'd0},
    '{WRITE_REG, AddrDotTicks, 32'h0000_FFFF, 1'b0, 19'd0},
    '{SEND_CHAR, AddrDotTicks, 32'(" "),      1'b1, 19'd458745},
    '{SEND_CHAR, AddrDotTicks, 32'("0"),      1'b0, 19'd0},
    '{SEND_CHAR, AddrDotTicks, 32'("@"),      1'b1, 19'd196605},
    '{WRITE_REG, AddrDotTicks, 32'hFFFF_0001, 1'b0, 19'd0},
    '{SEND_CHAR, AddrDotTicks, 32'(" "),      1'b1, 19'd7},
    '{SEND_CHAR, AddrDotTicks, 32'("["),      1'b1, 19'd3},
    '{SEND_CHAR, AddrDotTicks, 32'("/"),      1'b1, 19'd3},
    '{SEND_CHAR, AddrDotTicks, 32'(":"),      1'b1, 19'd3},
    '{WRITE_REG, AddrDotTicks, 32'h0000_0000, 1'b0, 19'd0},
    '{SEND_CHAR, AddrDotTicks, 32'("Q"),      1'b0, 19'd0},
    '{SEND_CHAR, AddrDotTicks, 32'(" "),      1'b1, 19'd0},
    '{WRITE_REG, AddrUnmapped, 32'h0000_1234, 1'b0, 19'd0},
    '{SEND_CHAR, AddrDotTicks, 32'("K"),      1'b0, 19'd0}
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [mkt_pkg::AddrW-1:0] paddr;
  logic [mkt_pkg::DataW-1:0] pwdata;
  logic [mkt_pkg::DataW-1:0] prdata;
  logic                      pready;

  mkt_char_if char_bus ();
  mkt_seg_if  seg_bus ();

  morse_keyer_timing_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_bus),
    .seg_o   (seg_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [mkt_pkg::DotW-1:0] dot_len;
  segment_t                 segments_due[$];
  int unsigned              mismatch_count;
  int unsigned              quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PrintCap) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  function automatic string morse_pattern(input logic [mkt_pkg::CharW-1:0] ch);
    case (ch)
      "A": return ".-";    "B": return "-...";  "C": return "-.-.";
      "D": return "-..";   "E": return ".";     "F": return "..-.";
      "G": return "--.";   "H": return "....";  "I": return "..";
      "J": return ".---";  "K": return "-.-";   "L": return ".-..";
      "M": return "--";    "N": return "-.";    "O": return "---";
      "P": return ".--.";  "Q": return "--.-";  "R": return ".-.";
      "S": return "...";   "T": return "-";     "U": return "..-";
      "V": return "...-";  "W": return ".--";   "X": return "-..-";
      "Y": return "-.--";  "Z": return "--..";
      "0": return "-----"; "1": return ".----"; "2": return "..---";
      "3": return "...--"; "4": return "....-"; "5": return ".....";
      "6": return "-....";  "7": return "--..."; "8": return "---..";
      "9": return "----.";
      default: return "";
    endcase
  endfunction

  function automatic void push_segment(input logic on, input int unsigned ticks,
                                       input logic fin);
    segment_t s;
    s.key_on = on;
    s.dur    = mkt_pkg::DurW'(ticks);
    s.last   = fin;
    segments_due.push_back(s);
  endfunction

  function automatic void queue_segments_for(input logic [mkt_pkg::CharW-1:0] ch);
    string       code;
    int unsigned dot;
    dot = 32'(dot_len);
    if (ch == mkt_pkg::CharSpace) begin
      push_segment(1'b0, dot * mkt_pkg::WordGapDots, 1'b1);
    end else begin
      code = morse_pattern(ch);
      for (int n = 0; n < code.len(); n++) begin
        push_segment(1'b1, (code[n] == "-") ? dot * mkt_pkg::DashDots : dot, 1'b0);
        push_segment(1'b0, dot, 1'b0);
      end
      push_segment(1'b0, dot * mkt_pkg::LetterGapDots, 1'b1);
    end
  endfunction

  function automatic logic [mkt_pkg::CharW-1:0] pick_character();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return mkt_pkg::CharW'("A" + $urandom_range(0, 25));
    if (roll < 75) return mkt_pkg::CharW'("0" + $urandom_range(0, 9));
    if (roll < 85) return mkt_pkg::CharSpace;
    return mkt_pkg::CharW'($urandom_range(0, 255));
  endfunction

  task automatic send_char(input logic [mkt_pkg::CharW-1:0] ch, input logic typed,
                           input logic [mkt_pkg::DurW-1:0] typed_dur);
    @(negedge clk_i);
    char_bus.valid     <= 1'b1;
    char_bus.character <= ch;
    do @(posedge clk_i); while (!char_bus.ready);
    if (typed) begin
      push_segment(1'b0, 32'(typed_dur), 1'b1);
    end else begin
      queue_segments_for(ch);
    end
  endtask

  task automatic hold_off(input int unsigned cycles);
    @(negedge clk_i);
    char_bus.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic settle_segments();
    @(negedge clk_i);
    char_bus.valid <= 1'b0;
    while (segments_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mkt_pkg::AddrW-1:0] addr,
                           input logic [mkt_pkg::DataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == AddrDotTicks) begin
      dot_len = data[mkt_pkg::DotW-1:0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin : seg_check
    segment_t want;
    if (rst_ni && seg_bus.valid && seg_bus.ready) begin
      if (segments_due.size() == 0) begin
        report_mismatch($sformatf("unexpected segment key_on=%0b dur=%0d last=%0b",
                                  seg_bus.key_on, seg_bus.duration_ticks, seg_bus.last));
      end else begin
        want = segments_due.pop_front();
        if (seg_bus.key_on !== want.key_on) begin
          report_mismatch($sformatf("key_on got %0b want %0b", seg_bus.key_on,
                                    want.key_on));
        end
        if (seg_bus.duration_ticks !== want.dur) begin
          report_mismatch($sformatf("duration_ticks got %0d want %0d",
                                    seg_bus.duration_ticks, want.dur));
        end
        if (seg_bus.last !== want.last) begin
          report_mismatch($sformatf("last got %0b want %0b", seg_bus.last, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((char_bus.valid && char_bus.ready) || (seg_bus.valid && seg_bus.ready)
                 || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : seg_sink
    int unsigned stall_left;
    int unsigned mode;
    int unsigned beat;
    seg_bus.ready = 1'b0;
    stall_left    = 0;
    mode          = 0;
    beat          = 0;
    forever begin
      @(negedge clk_i);
      if (beat % 128 == 0) begin
        mode = $urandom_range(0, 2);
      end
      beat++;
      if (stall_left > 0) begin
        seg_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        seg_bus.ready <= 1'b1;
        case (mode)
          1: begin
            if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
          end
          2: begin
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 20);
          end
          default: ;
        endcase
      end
    end
  end

  initial begin : char_source
    stim_row_t                row;
    int unsigned              burst_left;
    logic [mkt_pkg::DotW-1:0] phase_dot;
    rst_ni             = 1'b0;
    char_bus.valid     = 1'b0;
    char_bus.character = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    dot_len            = mkt_pkg::DotReset;
    mismatch_count     = 0;
    burst_left         = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NumRows; r++) begin
      row = DirectedRows[r];
      if (row.kind == WRITE_REG) begin
        settle_segments();
        write_reg(row.addr, row.value);
      end else begin
        send_char(row.value[mkt_pkg::CharW-1:0], row.typed, row.dur);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: phase_dot = 16'hFFFF;
        1: phase_dot = 16'd1;
        2: phase_dot = 16'd0;
        3: phase_dot = mkt_pkg::DotW'($urandom_range(2, 300));
        4: phase_dot = mkt_pkg::DotReset;
        default: phase_dot = mkt_pkg::DotW'($urandom_range(0, 65535));
      endcase
      settle_segments();
      write_reg(AddrDotTicks, {mkt_pkg::DotW'($urandom_range(0, 65535)), phase_dot});
      if (p == 2) begin
        write_reg(AddrUnmapped, $urandom);
      end
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 3 && i == PhaseItems / 2) begin
          settle_segments();
        end
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) begin
            hold_off($urandom_range(1, 12));
          end
          burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        send_char(pick_character(), 1'b0, '0);
      end
    end

    settle_segments();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ morse_keyer_timing_core.f @@
sv/mkt_pkg.sv
sv/mkt_if.sv
sv/morse_keyer_timing_core.sv
sv/mkt_checker.sv
bench/tb_morse_keyer_timing_core.sv
